// File: hdl/arac_pkg.sv
// Shared types and constants for the alert retransmission controller.
// Holds mode, action, journal and register index codes, the retry backoff windows
// with their reciprocal constants, and the structs passed between pipeline stages.
`default_nettype none

package arac_pkg;

    localparam int ID_W      = 32;
    localparam int TIMER_W   = 20;
    localparam int COUNT_W   = 8;
    localparam int JIT_W     = 16;
    localparam int BACKOFF_W = 14;
    localparam int SPAN_W    = 12;
    localparam int CFG_W     = 20;
    localparam int NUM_WIN   = 4;
    localparam int QUOT_W    = 8;
    localparam int RECIP_SH  = 32;
    localparam int RECIP_W   = 24;

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_PENDING   = 3'd1,
        MODE_WAITING   = 3'd2,
        MODE_CONFIRMED = 3'd3,
        MODE_FAILED    = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_TRIGGER = 2'd1,
        ACT_ACK     = 2'd2,
        ACT_RESUME  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        JOP_NONE         = 2'd0,
        JOP_SAVE_PENDING = 2'd1,
        JOP_SAVE_ACKED   = 2'd2
    } jop_t;

    localparam logic [1:0] CFG_ACK_TIMEOUT  = 2'd0;
    localparam logic [1:0] CFG_RETRY_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_FAILED_REARM = 2'd2;

    localparam logic [TIMER_W-1:0] CONFIRM_HOLD_TICKS = 20'd1000;
    localparam logic [TIMER_W-1:0] RESUME_DELAY_TICKS = 20'd500;
    localparam logic [TIMER_W-1:0] ACK_TIMEOUT_RESET  = 20'd3000;
    localparam logic [COUNT_W-1:0] RETRY_LIMIT_RESET  = 8'd4;
    localparam logic [TIMER_W-1:0] FAILED_REARM_RESET = 20'd60000;

    // Backoff windows, one per retry number; the last one serves all later retries.
    localparam logic [BACKOFF_W-1:0] WIN_LO [NUM_WIN] = '{14'd600, 14'd1800, 14'd4000, 14'd8000};
    localparam logic [BACKOFF_W-1:0] WIN_HI [NUM_WIN] = '{14'd900, 14'd2400, 14'd5000, 14'd10000};

    localparam logic [SPAN_W-1:0] WIN_SPAN [NUM_WIN] = '{
        SPAN_W'(WIN_HI[0] - WIN_LO[0] + 14'd1),
        SPAN_W'(WIN_HI[1] - WIN_LO[1] + 14'd1),
        SPAN_W'(WIN_HI[2] - WIN_LO[2] + 14'd1),
        SPAN_W'(WIN_HI[3] - WIN_LO[3] + 14'd1)
    };

    // Rounded-up reciprocals scaled by 2^32; exact for any 16-bit dividend.
    localparam logic [RECIP_W-1:0] WIN_RECIP [NUM_WIN] = '{
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(WIN_SPAN[0]) - 64'd1) / 64'(WIN_SPAN[0])),
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(WIN_SPAN[1]) - 64'd1) / 64'(WIN_SPAN[1])),
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(WIN_SPAN[2]) - 64'd1) / 64'(WIN_SPAN[2])),
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(WIN_SPAN[3]) - 64'd1) / 64'(WIN_SPAN[3]))
    };

    typedef struct packed {
        action_t                          action;
        logic [ID_W-1:0]                  new_event_id;
        logic [COUNT_W-1:0]               resume_attempt;
        logic [ID_W-1:0]                  ack_event_id;
        logic                             ack_frame_is_ack;
        logic                             origin_matches;
        logic [JIT_W-1:0]                 jitter;
        logic [NUM_WIN-1:0][QUOT_W-1:0]   jit_quot;
    } item_t;

    typedef struct packed {
        logic                   transmit_now;
        logic [ID_W-1:0]        tx_event_id;
        logic [COUNT_W-1:0]     tx_attempt;
        mode_t                  fsm_code;
        jop_t                   journal_op;
        logic [BACKOFF_W-1:0]   backoff_chosen;
        logic                   failed_now;
        logic                   confirmed_now;
    } result_t;

endpackage

`default_nettype wire

// File: hdl/alert_retransmit_ack_controller.sv
// Structure: an input register feeds the decision logic, whose result is loaded into the result
// register when that register is empty or is being emptied; out_ready low holds the word back.
// Throughput: one word per cycle while out_ready stays high; every word's decision and state
// update happen in one pass between the input register and the result register.
// Reset: asynchronous active low; clears the mode, counters, timer and valid flags and loads
// the configuration registers with their default values. No clearing pass is needed.
`default_nettype none

module alert_retransmit_ack_controller
    import arac_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_wdata,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [1:0]             action,
    input  wire logic [ID_W-1:0]        new_event_id,
    input  wire logic [COUNT_W-1:0]     resume_attempt,
    input  wire logic [ID_W-1:0]        ack_event_id,
    input  wire logic                   ack_frame_is_ack,
    input  wire logic                   origin_matches,
    input  wire logic [JIT_W-1:0]       jitter,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        transmit_now,
    output logic [ID_W-1:0]             tx_event_id,
    output logic [COUNT_W-1:0]          tx_attempt,
    output logic [2:0]                  fsm_code,
    output logic [1:0]                  journal_op,
    output logic [BACKOFF_W-1:0]        backoff_chosen,
    output logic                        failed_now,
    output logic                        confirmed_now
);

    item_t   item;
    logic    item_valid;
    logic    advance;
    result_t result;
    result_t out_word;

    arac_in_stage u_in_stage (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .action           (action),
        .new_event_id     (new_event_id),
        .resume_attempt   (resume_attempt),
        .ack_event_id     (ack_event_id),
        .ack_frame_is_ack (ack_frame_is_ack),
        .origin_matches   (origin_matches),
        .jitter           (jitter),
        .advance          (advance),
        .item_valid       (item_valid),
        .item             (item)
    );

    arac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .advance   (advance),
        .result    (result)
    );

    arac_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .out_ready  (out_ready),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_word   (out_word)
    );

    assign transmit_now   = out_word.transmit_now;
    assign tx_event_id    = out_word.tx_event_id;
    assign tx_attempt     = out_word.tx_attempt;
    assign fsm_code       = out_word.fsm_code;
    assign journal_op     = out_word.journal_op;
    assign backoff_chosen = out_word.backoff_chosen;
    assign failed_now     = out_word.failed_now;
    assign confirmed_now  = out_word.confirmed_now;

endmodule

`default_nettype wire

// File: hdl/arac_in_stage.sv
// Input register of the alert retransmission controller.
// Captures one input word and precomputes the jitter quotient for every backoff window.
// Depends on arac_pkg.
`default_nettype none

module arac_in_stage
    import arac_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           action,
    input  wire logic [ID_W-1:0]      new_event_id,
    input  wire logic [COUNT_W-1:0]   resume_attempt,
    input  wire logic [ID_W-1:0]      ack_event_id,
    input  wire logic                 ack_frame_is_ack,
    input  wire logic                 origin_matches,
    input  wire logic [JIT_W-1:0]     jitter,
    input  wire logic                 advance,
    output logic                      item_valid,
    output item_t                     item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;

    logic [JIT_W+RECIP_W-1:0] quot_prod [NUM_WIN];

    assign in_ready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        for (int w = 0; w < NUM_WIN; w++)
        begin
            quot_prod[w] = (JIT_W+RECIP_W)'(jitter) * (JIT_W+RECIP_W)'(WIN_RECIP[w]);
        end
    end

    always_comb
    begin
        item_next.action           = action_t'(action);
        item_next.new_event_id     = new_event_id;
        item_next.resume_attempt   = resume_attempt;
        item_next.ack_event_id     = ack_event_id;
        item_next.ack_frame_is_ack = ack_frame_is_ack;
        item_next.origin_matches   = origin_matches;
        item_next.jitter           = jitter;
        for (int w = 0; w < NUM_WIN; w++)
        begin
            item_next.jit_quot[w] = quot_prod[w][RECIP_SH +: QUOT_W];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/arac_ctrl.sv
// Retransmission state machine with its configuration registers.
// Decides each word from the input register and the held state in one pass.
// Depends on arac_pkg.
`default_nettype none

module arac_ctrl
    import arac_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_wdata,
    input  wire item_t              item,
    input  wire logic               advance,
    output result_t                 result
);

    logic [TIMER_W-1:0] ack_timeout_reg;
    logic [COUNT_W-1:0] retry_limit_reg;
    logic [TIMER_W-1:0] failed_rearm_reg;

    mode_t              mode_reg,    mode_next;
    logic [COUNT_W-1:0] retries_reg, retries_next;
    logic [TIMER_W-1:0] time_reg,    time_next;
    logic               pending_reg, pending_next;
    logic [ID_W-1:0]    event_reg,   event_next;

    logic [TIMER_W-1:0]   time_dec;
    logic                 due;
    logic                 ack_ok;
    logic [COUNT_W-1:0]   retries_inc;
    logic [1:0]           win_sel;
    logic [SPAN_W-1:0]    span_sel;
    logic [QUOT_W-1:0]    quot_sel;
    logic [TIMER_W-1:0]   quot_mul;
    logic [TIMER_W-1:0]   rem_raw;
    logic [SPAN_W-1:0]    rem;
    logic [BACKOFF_W-1:0] backoff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_timeout_reg  <= ACK_TIMEOUT_RESET;
            retry_limit_reg  <= RETRY_LIMIT_RESET;
            failed_rearm_reg <= FAILED_REARM_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_ACK_TIMEOUT)
            begin
                ack_timeout_reg <= cfg_wdata;
            end
            else if (cfg_index == CFG_RETRY_LIMIT)
            begin
                retry_limit_reg <= cfg_wdata[COUNT_W-1:0];
            end
            else if (cfg_index == CFG_FAILED_REARM)
            begin
                failed_rearm_reg <= cfg_wdata;
            end
        end
    end

    // Backoff: window minimum plus jitter modulo the window span.
    // The quotient comes from the input register; one correction step covers rounding.
    always_comb
    begin
        retries_inc = retries_reg + 8'd1;
        win_sel     = (retries_inc >= 8'd4) ? 2'd3 : 2'(retries_inc - 8'd1);
        span_sel    = WIN_SPAN[win_sel];
        quot_sel    = item.jit_quot[win_sel];
        quot_mul    = TIMER_W'(quot_sel) * TIMER_W'(span_sel);
        rem_raw     = TIMER_W'(item.jitter) - quot_mul;
        if (rem_raw >= TIMER_W'(span_sel))
        begin
            rem_raw = rem_raw - TIMER_W'(span_sel);
        end
        rem     = rem_raw[SPAN_W-1:0];
        backoff = WIN_LO[win_sel] + BACKOFF_W'(rem);
    end

    always_comb
    begin
        time_dec = (time_reg != '0) ? time_reg - 20'd1 : '0;
        due      = (time_dec == '0);
        ack_ok   = (mode_reg == MODE_WAITING) && pending_reg && item.ack_frame_is_ack
                   && item.origin_matches && (item.ack_event_id == event_reg);
    end

    always_comb
    begin
        mode_next    = mode_reg;
        retries_next = retries_reg;
        time_next    = time_reg;
        pending_next = pending_reg;
        event_next   = event_reg;
        result       = '0;

        unique case (item.action)
            ACT_TICK:
            begin
                time_next = time_dec;
                if (due)
                begin
                    unique case (mode_reg)
                        MODE_PENDING:
                        begin
                            if (pending_reg)
                            begin
                                result.transmit_now = 1'b1;
                                result.journal_op   = JOP_SAVE_PENDING;
                                mode_next           = MODE_WAITING;
                                time_next           = ack_timeout_reg;
                            end
                        end
                        MODE_WAITING:
                        begin
                            if (pending_reg)
                            begin
                                result.journal_op = JOP_SAVE_PENDING;
                                if (retries_reg >= retry_limit_reg)
                                begin
                                    result.failed_now = 1'b1;
                                    mode_next         = MODE_FAILED;
                                    time_next         = failed_rearm_reg;
                                end
                                else
                                begin
                                    retries_next          = retries_inc;
                                    result.backoff_chosen = backoff;
                                    mode_next             = MODE_PENDING;
                                    time_next             = TIMER_W'(backoff);
                                end
                            end
                        end
                        MODE_CONFIRMED:
                        begin
                            mode_next = MODE_IDLE;
                        end
                        MODE_FAILED:
                        begin
                            if (pending_reg)
                            begin
                                retries_next = '0;
                                mode_next    = MODE_PENDING;
                                time_next    = '0;
                            end
                        end
                        default:
                        begin
                            mode_next = mode_reg;
                        end
                    endcase
                end
            end
            ACT_TRIGGER:
            begin
                event_next        = item.new_event_id;
                retries_next      = '0;
                pending_next      = 1'b1;
                result.journal_op = JOP_SAVE_PENDING;
                mode_next         = MODE_PENDING;
                time_next         = '0;
            end
            ACT_ACK:
            begin
                if (ack_ok)
                begin
                    result.confirmed_now = 1'b1;
                    result.journal_op    = JOP_SAVE_ACKED;
                    pending_next         = 1'b0;
                    event_next           = '0;
                    retries_next         = '0;
                    mode_next            = MODE_CONFIRMED;
                    time_next            = CONFIRM_HOLD_TICKS;
                end
            end
            ACT_RESUME:
            begin
                event_next   = item.new_event_id;
                retries_next = item.resume_attempt;
                pending_next = 1'b1;
                mode_next    = MODE_PENDING;
                time_next    = RESUME_DELAY_TICKS;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        result.tx_event_id = event_next;
        result.tx_attempt  = retries_next;
        result.fsm_code    = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            retries_reg <= '0;
            time_reg    <= '0;
            pending_reg <= 1'b0;
            event_reg   <= '0;
        end
        else if (advance)
        begin
            mode_reg    <= mode_next;
            retries_reg <= retries_next;
            time_reg    <= time_next;
            pending_reg <= pending_next;
            event_reg   <= event_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/arac_out_stage.sv
// Result register of the alert retransmission controller.
// Holds one finished result word until the consumer takes it. Depends on arac_pkg.
`default_nettype none

module arac_out_stage
    import arac_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    input  wire result_t  result,
    input  wire logic     out_ready,
    output logic          advance,
    output logic          out_valid,
    output result_t       out_word
);

    logic    valid_reg;
    logic    valid_next;
    result_t word_reg;

    // A word moves on when the result register is empty or is being emptied.
    assign advance   = item_valid && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            word_reg <= result;
        end
    end

endmodule

`default_nettype wire

// File: hdl/arac_checker.sv
// Port-level checker for the alert retransmission controller, bound to the top level.
// Depends on arac_pkg for the widths, the mode and journal codes and the backoff windows.
`default_nettype none

module arac_checker
    import arac_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic                   transmit_now,
    input wire logic [ID_W-1:0]        tx_event_id,
    input wire logic [COUNT_W-1:0]     tx_attempt,
    input wire logic [2:0]             fsm_code,
    input wire logic [1:0]             journal_op,
    input wire logic [BACKOFF_W-1:0]   backoff_chosen,
    input wire logic                   failed_now,
    input wire logic                   confirmed_now
);

    // A stalled result word must stay valid and keep its event id and mode code.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tx_event_id) && $stable(fsm_code))
        else $error("result word changed while stalled");

    a_tx_waits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && transmit_now |->
            fsm_code == MODE_WAITING && journal_op == JOP_SAVE_PENDING)
        else $error("transmission without entering the ack wait");

    a_confirm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && confirmed_now |->
            fsm_code == MODE_CONFIRMED && journal_op == JOP_SAVE_ACKED
            && tx_event_id == '0 && tx_attempt == '0)
        else $error("confirmation did not clear the pending event");

    a_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && failed_now |->
            fsm_code == MODE_FAILED && backoff_chosen == '0 && !transmit_now)
        else $error("failure word is inconsistent");

    a_backoff: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && backoff_chosen != '0 |->
            fsm_code == MODE_PENDING && backoff_chosen >= WIN_LO[0]
            && backoff_chosen <= WIN_HI[NUM_WIN-1])
        else $error("backoff outside the retry windows");

endmodule

bind alert_retransmit_ack_controller arac_checker u_arac_checker (.*);

`default_nettype wire
